// ===== design/msft_pkg.sv =====
// ----------------------------------------------------------------------------
// msft_pkg
// Shared constants, types and codes for the split fan triangulation block.
// ----------------------------------------------------------------------------
package msft_pkg;

    // face and index geometry
    localparam int MAX_FACE_VERTICES = 32;
    localparam int POSITION_BITS     = 24;
    localparam int FACE_W            = 6;
    localparam int LIMIT_W           = 17;
    localparam int CORNER_W          = 16;
    localparam int COUNT_W           = FACE_W;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = LIMIT_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_WINDING = 2'd1;
    localparam logic [LIMIT_W-1:0]     VERTEX_LIMIT_RESET  = 17'd65000;

    // face sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CALC
    } state_t;

    // one face worth of triangle emission work
    typedef struct packed {
        logic [LIMIT_W-1:0]       apex;
        logic [COUNT_W-1:0]       tri_count;
        logic                     opens;
        logic                     oversize;
        logic                     reverse;
        logic [POSITION_BITS-1:0] first_index;
        logic [POSITION_BITS-1:0] first_face;
    } fan_job_t;

endpackage

// ===== design/msft_fan_emit.sv =====
// ----------------------------------------------------------------------------
// msft_fan_emit
// Walks the fan of one face, one triangle per accepted result or a flag if
// none, one incrementer per moving corner and a registered output stage.
// ----------------------------------------------------------------------------
module msft_fan_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  msft_pkg::fan_job_t                   job,
    input  logic                                 job_load,
    output logic                                 free,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msft_pkg::CORNER_W-1:0]        corner_first,
    output logic [msft_pkg::CORNER_W-1:0]        corner_second,
    output logic [msft_pkg::CORNER_W-1:0]        corner_third,
    output logic                                 has_triangle,
    output logic                                 opens_chunk,
    output logic [msft_pkg::POSITION_BITS-1:0]   chunk_first_index,
    output logic [msft_pkg::POSITION_BITS-1:0]   chunk_first_face,
    output logic                                 oversize_error,
    output logic                                 last_of_face
);
    import msft_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic                last_reg;
    logic                last_next;
    logic [COUNT_W-1:0]  remaining_reg;
    logic [COUNT_W-1:0]  remaining_next;
    logic                advance;
    logic                has_tri_load;
    logic [CORNER_W-1:0] apex_c;
    logic [CORNER_W-1:0] off_second;
    logic [CORNER_W-1:0] off_third;

    logic [CORNER_W-1:0]      first_reg;
    logic [CORNER_W-1:0]      second_reg;
    logic [CORNER_W-1:0]      third_reg;
    logic                     has_tri_reg;
    logic                     opens_reg;
    logic                     oversize_reg;
    logic [POSITION_BITS-1:0] first_index_reg;
    logic [POSITION_BITS-1:0] first_face_reg;

    // handshake and triangle countdown
    always_comb
    begin
        advance        = valid_reg && out_ready && !last_reg;
        free           = !valid_reg || (out_ready && last_reg);
        valid_next     = valid_reg;
        last_next      = last_reg;
        remaining_next = remaining_reg;
        if (job_load)
        begin
            valid_next     = 1'b1;
            last_next      = (job.tri_count <= COUNT_W'(1));
            remaining_next = job.tri_count;
        end
        else if (valid_reg && out_ready && last_reg)
        begin
            valid_next = 1'b0;
        end
        else if (advance)
        begin
            remaining_next = remaining_reg - COUNT_W'(1);
            last_next      = (remaining_reg == COUNT_W'(2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_reg      <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            last_reg      <= last_next;
            remaining_reg <= remaining_next;
        end
    end

    // corner offsets, swapped under reverse winding
    always_comb
    begin
        has_tri_load = (job.tri_count != '0);
        apex_c       = job.apex[CORNER_W-1:0];
        off_second   = job.reverse ? CORNER_W'(2) : CORNER_W'(1);
        off_third    = job.reverse ? CORNER_W'(1) : CORNER_W'(2);
    end

    // result payload, second and third corners stepped by their incrementers
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            first_reg       <= has_tri_load ? apex_c : '0;
            second_reg      <= has_tri_load ? apex_c + off_second : '0;
            third_reg       <= has_tri_load ? apex_c + off_third : '0;
            has_tri_reg     <= has_tri_load;
            opens_reg       <= job.opens;
            oversize_reg    <= job.oversize;
            first_index_reg <= job.first_index;
            first_face_reg  <= job.first_face;
        end
        else if (advance)
        begin
            second_reg <= second_reg + CORNER_W'(1);
            third_reg  <= third_reg + CORNER_W'(1);
        end
    end

    assign out_valid         = valid_reg;
    assign corner_first      = first_reg;
    assign corner_second     = second_reg;
    assign corner_third      = third_reg;
    assign has_triangle      = has_tri_reg;
    assign opens_chunk       = opens_reg;
    assign chunk_first_index = first_index_reg;
    assign chunk_first_face  = first_face_reg;
    assign oversize_error    = oversize_reg;
    assign last_of_face      = last_reg;

endmodule

// ===== design/mesh_split_fan_triangulation.sv =====
// ----------------------------------------------------------------------------
// mesh_split_fan_triangulation
// Packs polygon faces into vertex-limited chunks and emits chunk-local fan
// triangles: one result per triangle, or a flag result for a face with none.
// ----------------------------------------------------------------------------
// request: captured in ST_IDLE, loaded into the output register from ST_CALC
//   once the emitter is free, later while it still holds the previous face
// throughput: one result per cycle while out_ready is high and the sequencer
//   keeps up, set by the single emitter and the chunk update in ST_CALC
// the next face is taken while the previous face's triangles drain
// reset: counters cleared, vertex_limit 65000, reverse_winding 0, no output
module mesh_split_fan_triangulation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msft_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msft_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [msft_pkg::FACE_W-1:0]          face_vertices,
    input  logic                                 mesh_start,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msft_pkg::CORNER_W-1:0]        corner_first,
    output logic [msft_pkg::CORNER_W-1:0]        corner_second,
    output logic [msft_pkg::CORNER_W-1:0]        corner_third,
    output logic                                 has_triangle,
    output logic                                 opens_chunk,
    output logic [msft_pkg::POSITION_BITS-1:0]   chunk_first_index,
    output logic [msft_pkg::POSITION_BITS-1:0]   chunk_first_face,
    output logic                                 oversize_error,
    output logic                                 last_of_face
);
    import msft_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic               reverse_reg;

    logic [FACE_W-1:0]        n_reg;
    logic                     start_reg;
    logic [LIMIT_W-1:0]       total_reg;
    logic [LIMIT_W-1:0]       total_next;
    logic [POSITION_BITS-1:0] cs_pos_reg;
    logic [POSITION_BITS-1:0] cs_pos_next;
    logic [POSITION_BITS-1:0] cs_face_reg;
    logic [POSITION_BITS-1:0] cs_face_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] face_reg;
    logic [POSITION_BITS-1:0] face_next;

    logic [LIMIT_W-1:0]       base_total;
    logic [POSITION_BITS-1:0] base_cs_pos;
    logic [POSITION_BITS-1:0] base_cs_face;
    logic [POSITION_BITS-1:0] base_pos;
    logic [POSITION_BITS-1:0] base_face;
    logic [LIMIT_W:0]         fit_sum;
    logic [LIMIT_W-1:0]       apex;
    logic                     oversize;
    logic                     opens;
    logic [POSITION_BITS-1:0] pos_adv;
    logic [POSITION_BITS-1:0] face_adv;

    fan_job_t job;
    logic     job_load;
    logic     emit_free;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= VERTEX_LIMIT_RESET;
            reverse_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VERTEX_LIMIT:    limit_reg   <= cfg_data;
                CFG_REVERSE_WINDING: reverse_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // face request capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            n_reg     <= face_vertices;
            start_reg <= mesh_start;
        end
    end

    // chunk packing decision
    always_comb
    begin
        base_total   = start_reg ? '0 : total_reg;
        base_cs_pos  = start_reg ? '0 : cs_pos_reg;
        base_cs_face = start_reg ? '0 : cs_face_reg;
        base_pos     = start_reg ? '0 : pos_reg;
        base_face    = start_reg ? '0 : face_reg;

        oversize = ({{(LIMIT_W-FACE_W){1'b0}}, n_reg} >= limit_reg)
                   || (n_reg > FACE_W'(MAX_FACE_VERTICES));
        fit_sum  = {1'b0, base_total} + (LIMIT_W+1)'(n_reg);
        apex     = (fit_sum >= {1'b0, limit_reg}) ? '0 : base_total;
        opens    = (apex == '0);
        pos_adv  = base_pos + POSITION_BITS'(n_reg);
        face_adv = base_face + POSITION_BITS'(1);

        job.apex        = apex;
        job.reverse     = reverse_reg;
        job.oversize    = oversize;
        job.opens       = !oversize && opens;
        job.tri_count   = (oversize || n_reg < FACE_W'(3)) ? '0 : n_reg - FACE_W'(2);
        if (oversize)
        begin
            job.first_index = pos_adv;
            job.first_face  = face_adv;
        end
        else
        begin
            job.first_index = opens ? base_pos : base_cs_pos;
            job.first_face  = opens ? base_face : base_cs_face;
        end
    end

    // sequencer and counter update
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        job_load     = 1'b0;
        total_next   = total_reg;
        cs_pos_next  = cs_pos_reg;
        cs_face_next = cs_face_reg;
        pos_next     = pos_reg;
        face_next    = face_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (emit_free)
                begin
                    job_load     = 1'b1;
                    state_next   = ST_IDLE;
                    pos_next     = pos_adv;
                    face_next    = face_adv;
                    cs_pos_next  = job.first_index;
                    cs_face_next = job.first_face;
                    total_next   = oversize ? '0 : apex + LIMIT_W'(n_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            cs_pos_reg  <= '0;
            cs_face_reg <= '0;
            pos_reg     <= '0;
            face_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cs_pos_reg  <= cs_pos_next;
            cs_face_reg <= cs_face_next;
            pos_reg     <= pos_next;
            face_reg    <= face_next;
        end
    end

    // triangle emitter with output register
    msft_fan_emit u_emit (
        .clk               (clk),
        .rst_n             (rst_n),
        .job               (job),
        .job_load          (job_load),
        .free              (emit_free),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .corner_first      (corner_first),
        .corner_second     (corner_second),
        .corner_third      (corner_third),
        .has_triangle      (has_triangle),
        .opens_chunk       (opens_chunk),
        .chunk_first_index (chunk_first_index),
        .chunk_first_face  (chunk_first_face),
        .oversize_error    (oversize_error),
        .last_of_face      (last_of_face)
    );

endmodule
